### rtl/core/nonce_replay_window_defines.svh
// Assertion helpers for the nonce replay window.
// NRW_ASSERT checks on i_clk and is off while i_rst_n is low.
// NRW_ASSERT_ANY checks on i_clk at every edge.
`ifndef NONCE_REPLAY_WINDOW_DEFINES_SVH
`define NONCE_REPLAY_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS
`define NRW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("nonce_replay_window assertion failed");
`define NRW_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("nonce_replay_window assertion failed");
`else
`define NRW_ASSERT(lbl, prop)
`define NRW_ASSERT_ANY(lbl, prop)
`endif

`endif

### rtl/core/nrw_pkg.sv
`default_nettype none

package nrw_pkg;

    localparam int DEF_RING_DEPTH = 256;

    localparam int NONCE_LO_W = 64;
    localparam int NONCE_HI_W = 32;
    localparam int NONCE_W    = NONCE_LO_W + NONCE_HI_W;
    localparam int STATUS_W   = 2;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_GEN   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_FRESH  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REPLAY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_GEN    = 2'd2;

    localparam logic [NONCE_LO_W-1:0] COUNTER_RESET = 64'd2;
    localparam logic [NONCE_LO_W-1:0] COUNTER_STEP  = 64'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the incoming item, restart the scan
        logic issue;   // read ring entry at scan index, advance index
        logic store;   // write latched nonce at head, emit fresh/generated result
        logic reply;   // emit replay result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fill_zero;
        logic all_issued;
        logic pend;
        logic match;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/nrw_ram.sv
`default_nettype none

module nrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/nrw_dp.sv
`default_nettype none

`include "nonce_replay_window_defines.svh"

module nrw_dp
    import nrw_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd,
    input  wire logic [NONCE_LO_W-1:0] i_nonce_low,
    input  wire logic [NONCE_HI_W-1:0] i_nonce_high,
    input  wire t_dp_cmd               i_ctl,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [STATUS_W-1:0]   o_status,
    output logic      [NONCE_LO_W-1:0] o_out_nonce_low,
    output logic      [NONCE_HI_W-1:0] o_out_nonce_high
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);

    logic [FW-1:0]         r_fill;
    logic [AW-1:0]         r_head;
    logic [NONCE_LO_W-1:0] r_ctr;
    logic [FW-1:0]         r_idx;
    logic                  r_pend;
    logic                  r_out_valid;

    logic [NONCE_W-1:0]    r_nonce;
    logic                  r_gen;
    logic [STATUS_W-1:0]   r_status;
    logic [NONCE_LO_W-1:0] r_out_lo;

    logic [NONCE_W-1:0]    rd_data;
    logic                  emit;

    nrw_ram #(
        .WIDTH (NONCE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctl.store),
        .i_waddr (r_head),
        .i_wdata (r_nonce),
        .i_re    (i_ctl.issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign emit = i_ctl.store | i_ctl.reply;

    // filled entries are always 0 .. fill-1, so the scan runs from index 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_head      <= '0;
            r_ctr       <= COUNTER_RESET;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_ctl.issue;
            if (i_ctl.load) begin
                r_idx <= '0;
            end else if (i_ctl.issue) begin
                r_idx <= r_idx + FW'(1);
            end
            if (i_ctl.store) begin
                r_head <= (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + AW'(1);
                if (r_fill != FW'(RING_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
                if (r_gen) begin
                    r_ctr <= r_ctr + COUNTER_STEP;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_gen   <= (i_cmd == CMD_GEN);
            r_nonce <= (i_cmd == CMD_GEN) ? {NONCE_HI_W'(0), r_ctr}
                                          : {i_nonce_high, i_nonce_low};
        end
        if (i_ctl.reply) begin
            r_status <= STATUS_REPLAY;
            r_out_lo <= '0;
        end else if (i_ctl.store) begin
            r_status <= r_gen ? STATUS_GEN : STATUS_FRESH;
            r_out_lo <= r_gen ? r_nonce[NONCE_LO_W-1:0] : '0;
        end
    end

    always_comb begin
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.all_issued = (r_idx == r_fill);
        o_stat.pend       = r_pend;
        o_stat.match      = r_pend && (rd_data == r_nonce);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_nonce_low  = r_out_lo;
    assign o_out_nonce_high = '0;

    `NRW_ASSERT(a_fill_bound, r_fill <= FW'(RING_DEPTH))
    `NRW_ASSERT(a_head_tracks_fill, (r_fill < FW'(RING_DEPTH)) |-> (r_head == r_fill[AW-1:0]))
    `NRW_ASSERT(a_emit_slot_free, emit |-> (!r_out_valid || i_out_ready))
    `NRW_ASSERT(a_ctr_even, r_ctr[0] == 1'b0)
    `NRW_ASSERT(a_scan_in_fill, i_ctl.issue |-> (r_idx < r_fill))

endmodule

`default_nettype wire

### rtl/core/nrw_ctrl.sv
`default_nettype none

module nrw_ctrl
    import nrw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_cmd,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_STORE = 4'b0100,
        S_REPLY = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_ctl.load  = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_GEN || i_stat.fill_zero) begin
                        n_state = S_STORE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one read per cycle; data returns in the cycle after the read
                if (i_stat.match) begin
                    n_state = S_REPLY;
                end else if (i_stat.all_issued && !i_stat.pend) begin
                    n_state = S_STORE;
                end else begin
                    o_ctl.issue = !i_stat.all_issued;
                end
            end
            S_STORE: begin
                if (i_stat.out_free) begin
                    o_ctl.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_ctl.reply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/core/nonce_replay_window.sv
// Anti-replay cache for 96-bit nonces. A check command scans the filled ring
// entries one per cycle through the single read port of the ring memory. On a
// non-empty ring a fresh nonce is stored only after every filled entry has
// been compared; a replay ends the scan at the matching entry. A generate
// command, or a check on an empty ring, skips the scan. Output backpressure
// holds a result back until the output register is free. One item is in
// work at a time, and the next input transfer is taken from the cycle after
// the result is issued. The result register lets that next item be taken
// while a result waits. No clearing pass follows reset: the fill count keeps
// unwritten entries out of every scan.
`default_nettype none

module nonce_replay_window
    import nrw_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_cmd,
    input  wire logic [NONCE_LO_W-1:0] i_nonce_low,
    input  wire logic [NONCE_HI_W-1:0] i_nonce_high,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [STATUS_W-1:0]   o_status,
    output logic      [NONCE_LO_W-1:0] o_out_nonce_low,
    output logic      [NONCE_HI_W-1:0] o_out_nonce_high
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    nrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    nrw_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (i_cmd),
        .i_nonce_low      (i_nonce_low),
        .i_nonce_high     (i_nonce_high),
        .i_ctl            (ctl),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_out_nonce_low  (o_out_nonce_low),
        .o_out_nonce_high (o_out_nonce_high)
    );

endmodule

`default_nettype wire

### test/nonce_replay_window_test.sv
`default_nettype none

module nonce_replay_window_test;
    import nrw_pkg::*;

    localparam int DEPTH        = DEF_RING_DEPTH;
    localparam int RANDOM_ITEMS = 780;
    localparam int CALM_ITEMS   = 150;
    localparam int PAUSE_AT     = 300;
    // worst quiet stretch: full scan plus both sides idling, taken several times over
    localparam int STALL_LIMIT  = 4 * (DEPTH + 3 + 10 + 10);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [NONCE_LO_W-1:0] lo;
        logic [NONCE_HI_W-1:0] hi;
    } t_verdict;

    typedef struct packed {
        logic                  cmd;
        logic [NONCE_LO_W-1:0] lo;
        logic [NONCE_HI_W-1:0] hi;
        logic                  known;
        t_verdict              want;
    } t_probe;

    typedef enum int {
        PICK_FRESH,
        PICK_REPLAY,
        PICK_EVICTED,
        PICK_NEAR,
        PICK_AHEAD,
        PICK_GEN
    } t_pick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = CMD_CHECK;
    logic [NONCE_LO_W-1:0] i_nonce_low = '0;
    logic [NONCE_HI_W-1:0] i_nonce_high = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [NONCE_LO_W-1:0] o_out_nonce_low;
    logic [NONCE_HI_W-1:0] o_out_nonce_high;

    nonce_replay_window #(
        .RING_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_cmd(i_cmd),
        .i_nonce_low(i_nonce_low),
        .i_nonce_high(i_nonce_high),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_out_nonce_low(o_out_nonce_low),
        .o_out_nonce_high(o_out_nonce_high)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the nonce cache
    logic [NONCE_W-1:0]    seen_ring [DEPTH];
    int                    seen_head = 0;
    int                    seen_fill = 0;
    logic [NONCE_LO_W-1:0] gen_counter = COUNTER_RESET;
    logic [NONCE_W-1:0]    stored_log [$];

    t_verdict pending_verdicts [$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       out_stall = 0;
    logic     calm = 1'b0;

    t_probe probes [18] = '{
        '{CMD_GEN,   64'd0, 32'd0, 1'b1, '{STATUS_GEN, 64'd2, 32'd0}},
        '{CMD_CHECK, 64'd0, 32'd0, 1'b1, '{STATUS_FRESH, 64'd0, 32'd0}},
        '{CMD_CHECK, 64'd0, 32'd0, 1'b1, '{STATUS_REPLAY, 64'd0, 32'd0}},
        '{CMD_CHECK, '1, '1, 1'b1, '{STATUS_FRESH, 64'd0, 32'd0}},
        '{CMD_CHECK, '1, '1, 1'b1, '{STATUS_REPLAY, 64'd0, 32'd0}},
        '{CMD_CHECK, 64'd2, 32'd0, 1'b1, '{STATUS_REPLAY, 64'd0, 32'd0}},
        '{CMD_CHECK, 64'd2, 32'd1, 1'b1, '{STATUS_FRESH, 64'd0, 32'd0}},
        '{CMD_CHECK, 64'd4, 32'd0, 1'b1, '{STATUS_FRESH, 64'd0, 32'd0}},
        // counter lands on a nonce already cached: stored again, no check
        '{CMD_GEN,   64'd0, 32'd0, 1'b1, '{STATUS_GEN, 64'd4, 32'd0}},
        '{CMD_CHECK, 64'd4, 32'd0, 1'b1, '{STATUS_REPLAY, 64'd0, 32'd0}},
        '{CMD_GEN,   '1, '1, 1'b1, '{STATUS_GEN, 64'd6, 32'd0}},
        '{CMD_CHECK, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1,
          '{STATUS_FRESH, 64'd0, 32'd0}},
        '{CMD_CHECK, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{CMD_CHECK, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_CHECK, 64'd1, 32'd0, 1'b0, '0},
        '{CMD_CHECK, 64'd0, 32'd1, 1'b0, '0},
        '{CMD_GEN,   64'd0, 32'd0, 1'b0, '0}
    };

    function automatic void keep_nonce(input logic [NONCE_W-1:0] n);
        seen_ring[seen_head] = n;
        seen_head = (seen_head == DEPTH - 1) ? 0 : seen_head + 1;
        if (seen_fill < DEPTH) seen_fill++;
        stored_log.push_back(n);
    endfunction

    function automatic t_verdict screen_nonce(input logic cmd, input logic [NONCE_LO_W-1:0] lo,
                                              input logic [NONCE_HI_W-1:0] hi);
        t_verdict v;
        logic     hit;
        v = '0;
        hit = 1'b0;
        if (cmd == CMD_CHECK) begin
            for (int i = 0; i < seen_fill; i++) begin
                if (seen_ring[i] == {hi, lo}) hit = 1'b1;
            end
            if (hit) begin
                v.status = STATUS_REPLAY;
            end else begin
                keep_nonce({hi, lo});
                v.status = STATUS_FRESH;
            end
        end else begin
            keep_nonce({{NONCE_HI_W{1'b0}}, gen_counter});
            v.status = STATUS_GEN;
            v.lo = gen_counter;
            gen_counter = gen_counter + COUNTER_STEP;
        end
        return v;
    endfunction

    // leaves valid high after the transfer, so back-to-back items only drop it for a random idle gap
    task automatic send_item(input logic cmd, input logic [NONCE_LO_W-1:0] lo,
                             input logic [NONCE_HI_W-1:0] hi, input logic known,
                             input t_verdict want);
        t_verdict v;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_nonce_low <= lo;
        i_nonce_high <= hi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        v = screen_nonce(cmd, lo, hi);
        pending_verdicts.push_back(known ? want : v);
    endtask

    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            out_stall <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d low %h high %h",
                             o_status, o_out_nonce_low, o_out_nonce_high);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_status !== want.status || o_out_nonce_low !== want.lo ||
                    o_out_nonce_high !== want.hi) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d low %h high %h, got status %0d low %h high %h",
                                 want.status, want.lo, want.hi,
                                 o_status, o_out_nonce_low, o_out_nonce_high);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_pick                 pick;
        int                    roll;
        int                    idx;
        logic                  cmd;
        logic [NONCE_LO_W-1:0] lo;
        logic [NONCE_HI_W-1:0] hi;
        logic [NONCE_W-1:0]    n;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k])
            send_item(probes[k].cmd, probes[k].lo, probes[k].hi, probes[k].known, probes[k].want);

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (item == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_verdicts.size() != 0) @(posedge i_clk);
            end

            roll = $urandom_range(0, 99);
            if (roll < 30) pick = PICK_FRESH;
            else if (roll < 55) pick = PICK_REPLAY;
            else if (roll < 65) pick = PICK_EVICTED;
            else if (roll < 72) pick = PICK_NEAR;
            else if (roll < 78) pick = PICK_AHEAD;
            else pick = PICK_GEN;

            cmd = CMD_CHECK;
            lo = {$urandom, $urandom};
            hi = ($urandom_range(0, 7) == 0) ? '0 : NONCE_HI_W'($urandom);
            case (pick)
                PICK_REPLAY, PICK_NEAR: begin
                    if (seen_fill > 0) begin
                        n = seen_ring[$urandom_range(0, seen_fill - 1)];
                        if (pick == PICK_NEAR) n[$urandom_range(0, NONCE_W - 1)] ^= 1'b1;
                        {hi, lo} = n;
                    end
                end
                PICK_EVICTED: begin
                    // stored long enough ago that the ring has wrapped past it
                    if (stored_log.size() > DEPTH) begin
                        idx = $urandom_range(0, stored_log.size() - DEPTH - 1);
                        {hi, lo} = stored_log[idx];
                    end
                end
                PICK_AHEAD: begin
                    lo = gen_counter + NONCE_LO_W'(2 * $urandom_range(0, 5));
                    hi = '0;
                end
                PICK_GEN: begin
                    cmd = CMD_GEN;
                end
                default: ;
            endcase
            send_item(cmd, lo, hi, 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);

        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
